>>> sv/wf_pkg.sv
// Package for the 3x3 window filter: payload types, register indexes, mode codes.
package wf_pkg;

  localparam int unsigned MaxWidthDefault = 1024;

  // Register indexes on the configuration port
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  // Filter modes
  localparam logic [2:0] ModeBox      = 3'd0;
  localparam logic [2:0] ModeWeighted = 3'd1;
  localparam logic [2:0] ModeMedian   = 3'd2;
  localparam logic [2:0] ModeCross    = 3'd3;
  localparam logic [2:0] ModeFull     = 3'd4;

  // floor(x/9) = (x*Recip9) >> Recip9Shift for x up to 2295
  localparam logic [11:0] Recip9      = 12'd3641;
  localparam int unsigned Recip9Shift = 15;

  typedef logic [23:0] pix_t;        // {red, green, blue}
  typedef pix_t [2:0] column_t;      // index 0 is the top row

  typedef struct packed {
    logic       start_of_frame;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  blue_out;
    logic [7:0]  green_out;
    logic [7:0]  red_out;
    logic [9:0]  out_col;
    logic [11:0] out_row;
  } out_t;

endpackage

>>> sv/wf_col_cell.sv
// One column cell of the 3x3 window: holds three pixels, passes them left.
module wf_col_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  wf_pkg::column_t col_i,
  output wf_pkg::column_t col_o
);
  import wf_pkg::*;

  column_t col_q;

  // take the neighbor's column on every pixel shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

>>> sv/wf_filter.sv
// Two-stage filter datapath for one 8-bit channel of the 3x3 window.
module wf_filter (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [2:0] mode_i,
  input  logic [7:0] p_i [9],
  output logic [7:0] res_o
);
  import wf_pkg::*;

  function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // stage A: sums and per-row sort
  logic [9:0]         edge_s, corner_s;
  logic [7:0]         lo_d [3], md_d [3], hi_d [3];
  logic [7:0]         lo_q [3], md_q [3], hi_q [3];
  logic [11:0]        box_q, wsum_q;
  logic signed [11:0] cross_q;
  logic signed [12:0] full_q;
  logic [7:0]         mid_q;

  assign edge_s   = 10'(p_i[1]) + 10'(p_i[3]) + 10'(p_i[5]) + 10'(p_i[7]);
  assign corner_s = 10'(p_i[0]) + 10'(p_i[2]) + 10'(p_i[6]) + 10'(p_i[8]);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo_d[r] = min2(min2(p_i[3*r], p_i[3*r+1]), p_i[3*r+2]);
      hi_d[r] = max2(max2(p_i[3*r], p_i[3*r+1]), p_i[3*r+2]);
      md_d[r] = med3(p_i[3*r], p_i[3*r+1], p_i[3*r+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      box_q   <= 12'(corner_s) + 12'(edge_s) + 12'(p_i[4]);
      wsum_q  <= 12'(corner_s) + {1'b0, edge_s, 1'b0} + {2'b0, p_i[4], 2'b0};
      cross_q <= $signed(12'(p_i[4]) * 12'd5) - $signed({2'b0, edge_s});
      full_q  <= $signed(13'(p_i[4]) * 13'd9) - $signed({3'b0, edge_s})
                 - $signed({3'b0, corner_s});
      mid_q   <= p_i[4];
      lo_q    <= lo_d;
      md_q    <= md_d;
      hi_q    <= hi_d;
    end
  end

  // stage B: divide by nine, median merge, clamp, mode select
  logic [23:0] prod;
  logic [7:0]  med, cross_c, full_c, res_d;

  assign prod = 24'(box_q) * 24'(Recip9);
  assign med  = med3(max2(max2(lo_q[0], lo_q[1]), lo_q[2]),
                     med3(md_q[0], md_q[1], md_q[2]),
                     min2(min2(hi_q[0], hi_q[1]), hi_q[2]));
  assign cross_c = cross_q[11] ? 8'd0 : ((cross_q > 12'sd255) ? 8'd255 : cross_q[7:0]);
  assign full_c  = full_q[12] ? 8'd0 : ((full_q > 13'sd255) ? 8'd255 : full_q[7:0]);

  always_comb begin
    case (mode_i)
      ModeBox:      res_d = prod[Recip9Shift +: 8];
      ModeWeighted: res_d = wsum_q[11:4];
      ModeMedian:   res_d = med;
      ModeCross:    res_d = cross_c;
      ModeFull:     res_d = full_c;
      default:      res_d = mid_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

>>> sv/window_filter_3x3.sv
// Top level of the 3x3 window filter: counters, line store, window cells, filters.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i    | pixels in
//  out     | out_valid_o, out_ready_i, out_data_o | filtered interior pixels
//  cfg     | cfg_valid_i, cfg_ready_o, index/data | register writes
//
// One pixel per cycle unless the output stalls; an accepted pixel's result passes
// the line store read, the window shift and two filter stages. The line store is
// one dual-ported RAM read and written once per cycle while the pipeline runs.
// Reset clears counters, window and pipeline valids; the line store is not
// cleared. A stall on the output freezes the whole pipeline and drops in_ready_o.
module window_filter_3x3 #(
  parameter int unsigned MAX_WIDTH = wf_pkg::MaxWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  wf_pkg::in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output wf_pkg::out_t out_data_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [11:0]  cfg_data_i
);
  import wf_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);

  // configuration registers
  logic [10:0] width_q;
  logic [11:0] height_q;
  logic [2:0]  mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd256;
      height_q <= 12'd256;
      mode_q   <= ModeBox;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i[10:0];
        RegHeight: height_q <= cfg_data_i;
        RegMode:   mode_q   <= cfg_data_i[2:0];
        default:   ;
      endcase
    end
  end

  // pipeline advance
  logic en, in_acc, out_v_q;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;
  assign in_acc     = in_valid_i && en;

  // position counters
  logic [9:0]  col_q, col_d, c0;
  logic [11:0] row_q, row_d, r0;
  logic [12:0] w_eff;
  logic [11:0] h_eff;
  logic [AW-1:0] addr0;
  logic        emit0;

  always_comb begin
    w_eff = {2'b0, width_q};
    if (w_eff < 13'd3) w_eff = 13'd3;
    if (w_eff > MaxW) w_eff = MaxW;
    h_eff = (height_q < 12'd3) ? 12'd3 : height_q;
    c0 = in_data_i.start_of_frame ? 10'd0 : col_q;
    r0 = in_data_i.start_of_frame ? 12'd0 : row_q;
    emit0 = (r0 >= 12'd2) && (c0 >= 10'd2);
    addr0 = ({3'b0, c0} >= MaxW) ? '0 : AW'(32'(c0));
    if ({3'b0, c0} + 13'd1 >= w_eff) begin
      col_d = 10'd0;
      row_d = ({1'b0, r0} + 13'd1 >= {1'b0, h_eff}) ? 12'd0 : r0 + 12'd1;
    end else begin
      col_d = c0 + 10'd1;
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 registers: pixel waiting for its line store read
  logic          s1_v_q, s1_emit_q;
  pix_t          s1_px_q;
  logic [AW-1:0] s1_addr_q;
  logic [9:0]    s1_col_q;
  logic [11:0]   s1_row_q;

  // line store: {upper row, middle row} per column
  logic [47:0] line_mem [MAX_WIDTH];
  logic [47:0] rd_q, byp_d_q, rd_eff;
  logic        byp_q;
  pix_t        up_px, mid_px;

  assign rd_eff = byp_q ? byp_d_q : rd_q;
  assign up_px  = rd_eff[47:24];
  assign mid_px = rd_eff[23:0];

  always_ff @(posedge clk_i) begin
    if (en && s1_v_q) begin
      line_mem[s1_addr_q] <= {mid_px, s1_px_q};
    end
  end

  // read, with forwarding of the write to the same column
  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q    <= line_mem[addr0];
      byp_d_q <= {mid_px, s1_px_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (en) begin
      byp_q <= s1_v_q && (s1_addr_q == addr0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_px_q   <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
      s1_addr_q <= addr0;
      s1_col_q  <= c0 - 10'd1;
      s1_row_q  <= r0 - 12'd1;
      s1_emit_q <= emit0;
    end
  end

  // window: three column cells, right one takes the new column
  column_t cell_in [3];
  column_t cell_out [3];
  logic    shift;
  assign shift = en && s1_v_q;

  assign cell_in[2] = {s1_px_q, mid_px, up_px};
  assign cell_in[1] = cell_out[2];
  assign cell_in[0] = cell_out[1];

  for (genvar g = 0; g < 3; g++) begin : g_cell
    wf_col_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (shift),
      .col_i (cell_in[g]),
      .col_o (cell_out[g])
    );
  end

  // pipeline valids, and stage 2, stage 3 and output coordinates
  logic        s2_v_q, s3_v_q;
  logic [9:0]  s2_col_q, s3_col_q, o_col_q;
  logic [11:0] s2_row_q, s3_row_q, o_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q && s1_emit_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_col_q <= s1_col_q;
      s2_row_q <= s1_row_q;
      s3_col_q <= s2_col_q;
      s3_row_q <= s2_row_q;
      o_col_q  <= s3_col_q;
      o_row_q  <= s3_row_q;
    end
  end

  // per-channel filters on the window
  logic [7:0] res [3];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [7:0] p [9];
    for (genvar i = 0; i < 9; i++) begin : g_tap
      assign p[i] = cell_out[i % 3][i / 3][8*k +: 8];
    end
    wf_filter u_filter (
      .clk_i (clk_i),
      .en_i  (en),
      .mode_i(mode_q),
      .p_i   (p),
      .res_o (res[k])
    );
  end

  assign out_valid_o          = out_v_q;
  assign out_data_o.blue_out  = res[0];
  assign out_data_o.green_out = res[1];
  assign out_data_o.red_out   = res[2];
  assign out_data_o.out_col   = o_col_q;
  assign out_data_o.out_row   = o_row_q;

`ifndef SYNTHESIS
  // an accepted pixel is in stage 1 on the next cycle
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_v_q)
    else $error("accepted pixel missing in stage 1");

  // only interior pixels are emitted
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_col != 10'd0) && (out_data_o.out_row != 12'd0))
    else $error("border pixel emitted");

  // forwarding only follows a pending write
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(byp_q) |-> $past(s1_v_q))
    else $error("bypass without a write");
`endif

endmodule

>>> verif/tb_window_filter_3x3.sv
// Testbench for the 3x3 window filter: random and directed frames checked against a predictor.
module tb_window_filter_3x3;
  timeunit 1ns;
  timeprecision 1ps;
  import wf_pkg::*;

  localparam int unsigned MaxW = 1024;
  localparam int unsigned StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegWidth;
  logic [11:0] cfg_data_i = '0;

  window_filter_3x3 i_dut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state
  pix_t        upper_row [MaxW];
  pix_t        middle_row [MaxW];
  pix_t        win [9];
  int unsigned col_pos, row_pos;
  logic [10:0] cur_width = 11'd256;
  logic [11:0] cur_height = 12'd256;
  logic [2:0]  cur_mode = ModeBox;
  out_t        expected_pixels [$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          timed_out = 0;

  // Kernel on one channel; p[4] is the centre
  function automatic logic [7:0] filter_chan(input logic [7:0] p [9]);
    int edges, corners, ctr, v;
    logic [7:0] t;
    logic [7:0] s [9];
    edges = p[1] + p[3] + p[5] + p[7];
    corners = p[0] + p[2] + p[6] + p[8];
    ctr = p[4];
    case (cur_mode)
      ModeBox:      return 8'((corners + edges + ctr) / 9);
      ModeWeighted: return 8'((corners + 2 * edges + 4 * ctr) / 16);
      ModeMedian: begin
        s = p;
        for (int i = 1; i < 9; i++)
          for (int j = i; j > 0 && s[j-1] > s[j]; j--) begin
            t = s[j]; s[j] = s[j-1]; s[j-1] = t;
          end
        return s[4];
      end
      ModeCross, ModeFull: begin
        v = (cur_mode == ModeCross) ? 5 * ctr - edges : 9 * ctr - edges - corners;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      end
      default: return ctr[7:0];
    endcase
  endfunction

  // Advance the predictor by one accepted pixel
  task automatic predict_pixel(input in_t px_in);
    int unsigned w, h, c;
    pix_t up, md, px;
    logic [7:0] p [9];
    logic [7:0] res [3];
    out_t r;
    w = cur_width < 3 ? 3 : (cur_width > MaxW ? MaxW : cur_width);
    h = cur_height < 3 ? 3 : cur_height;
    if (px_in.start_of_frame) begin
      col_pos = 0; row_pos = 0;
    end
    px = {px_in.red_in, px_in.green_in, px_in.blue_in};
    c = col_pos >= MaxW ? 0 : col_pos;
    up = upper_row[c]; md = middle_row[c];
    upper_row[c] = md; middle_row[c] = px;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1]; win[i*3+1] = win[i*3+2];
    end
    win[2] = up; win[5] = md; win[8] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 9; i++) p[i] = win[i][8*k +: 8];
        res[k] = filter_chan(p);
      end
      r.blue_out = res[0]; r.green_out = res[1]; r.red_out = res[2];
      r.out_col = 10'(col_pos - 1); r.out_row = 12'(row_pos - 1);
      expected_pixels.push_back(r);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else col_pos = col_pos + 1;
  endtask

  // Send one pixel and wait for its transaction; valid stays up for the next one
  task automatic send_pixel(input bit sof, input logic [23:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{start_of_frame: sof, blue_in: rgb[7:0], green_in: rgb[15:8],
                   red_in: rgb[23:16]};
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixel(in_data_i);
    @(negedge clk_i);
  endtask

  // Wait out all expected results plus pipeline latency
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegWidth:  cur_width = val[10:0];
      RegHeight: cur_height = val;
      RegMode:   cur_mode = val[2:0];
      default:   ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic setup(input int w, input int h, input logic [2:0] mode);
    drain();
    write_reg(RegWidth, w[11:0]);
    write_reg(RegHeight, h[11:0]);
    write_reg(RegMode, mode);
    cfg_valid_i <= 1'b0;
  endtask

  // One frame of pixels; kind 0 random, 1 all zero, 2 all ones, 3 checker
  task automatic send_frame(input int w, input int h, input int kind);
    logic [23:0] v;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        case (kind)
          1: v = '0;
          2: v = '1;
          3: v = ((x + y) % 2) ? 24'hFFFFFF : 24'h000000;
          default: v = 24'($urandom());
        endcase
        send_pixel(x == 0 && y == 0, v);
      end
  endtask

  // Flat and extreme frames through every mode
  task automatic test_directed_modes;
    for (int m = ModeBox; m <= ModeFull; m++) begin
      setup(3, 3, m[2:0]);
      send_frame(3, 3, 3);
      send_frame(3, 3, 2);
    end
    setup(3, 3, 3'd7);
    send_frame(3, 3, 1);
  endtask

  // Register values below range: width and height act as 3
  task automatic test_size_clamp;
    setup(0, 1, ModeMedian);
    send_frame(3, 3, 0);
    setup(2, 0, ModeFull);
    send_frame(3, 6, 0);
  endtask

  // Random frames and modes under one idling phase
  task automatic test_random_frames(input int unsigned sidle, input int unsigned rstall,
                                    input int unsigned budget);
    int unsigned sent, w, h;
    send_idle_pct = sidle; recv_stall_pct = rstall;
    sent = 0;
    while (sent < budget) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 3);
      h = ($urandom_range(9) == 0) ? $urandom_range(6, 3) : $urandom_range(8, 3);
      if (w > 12) h = 3;
      setup(w, h, 3'($urandom_range(4)));
      send_frame(w, h, 0);
      sent += w * h;
    end
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  // Frames running past their end wrap onto a new frame without a start marker
  task automatic test_wraparound;
    setup(4, 3, ModeCross);
    for (int i = 0; i < 36; i++) send_pixel(i == 0, 24'($urandom()));
  endtask

  // Receiver ready with random stalls
  always @(negedge clk_i)
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        out_t e;
        e = expected_pixels.pop_front();
        if (out_data_o !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p got %p", e, out_data_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit && !timed_out) begin
      timed_out = 1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos = 0; row_pos = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_modes();
    test_size_clamp();
    test_wraparound();
    test_random_frames(0, 0, 430);
    test_random_frames(83, 0, 400);
    test_random_frames(0, 83, 400);
    test_random_frames(31, 31, 430);
    drain();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/wf_pkg.sv
sv/wf_col_cell.sv
sv/wf_filter.sv
sv/window_filter_3x3.sv
verif/tb_window_filter_3x3.sv
